// File: rtl/core/tcw_pkg.sv
package tcw_pkg;

    // cell and character constants
    localparam logic [15:0] BLANK_CELL = 16'h0120;
    localparam int          TAB_STOP   = 4;
    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_TAB     = 8'h09;

    // request action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCR_RD,
        S_SCR_WR,
        S_SCR_BLK,
        S_CLR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_REQ,
        MEM_PUT,
        MEM_SCR_RD,
        MEM_SCR_WR,
        MEM_BLANK
    } mem_op_t;

    typedef struct packed {
        logic    req_load;
        logic    cur_step;
        logic    cur_home;
        logic    ptr_clear;
        logic    ptr_inc;
        mem_op_t mem_op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       is_glyph;
        logic       needs_scroll;
        logic       copy_end;
        logic       fill_end;
        logic       out_free;
    } status_t;

endpackage

// File: rtl/core/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mem_op = MEM_NONE;
        case (state_reg)
            S_INIT:
            begin
                // power-up blanking pass
                cmd.mem_op  = MEM_BLANK;
                cmd.ptr_inc = 1'b1;
                if (status.fill_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    cmd.mem_op   = MEM_RD_REQ;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.action)
                    ACT_PUT:
                    begin
                        cmd.cur_step = 1'b1;
                        if (status.is_glyph)
                        begin
                            cmd.mem_op = MEM_PUT;
                        end
                        if (status.needs_scroll)
                        begin
                            cmd.ptr_clear = 1'b1;
                            state_next    = S_SCR_RD;
                        end
                        else if (status.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.cur_home  = 1'b1;
                        cmd.ptr_clear = 1'b1;
                        state_next    = S_CLR;
                    end
                    default:
                    begin
                        // read and the unused code: result is ready now
                        if (status.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_SCR_RD:
            begin
                cmd.mem_op = MEM_SCR_RD;
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                cmd.mem_op  = MEM_SCR_WR;
                cmd.ptr_inc = 1'b1;
                state_next  = status.copy_end ? S_SCR_BLK : S_SCR_RD;
            end
            S_SCR_BLK:
            begin
                cmd.mem_op  = MEM_BLANK;
                cmd.ptr_inc = 1'b1;
                if (status.fill_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLR:
            begin
                cmd.mem_op  = MEM_BLANK;
                cmd.ptr_inc = 1'b1;
                if (status.fill_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// File: rtl/core/tcw_dp.sv
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color,
    input  logic [4:0]  cell_row,
    input  logic [6:0]  cell_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled,
    output logic [15:0] read_data
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [AW-1:0] FILL_LAST = AW'(DEPTH - 1);
    localparam logic [CW:0]   TAB_MASK  = ~(CW + 1)'(TAB_STOP - 1);

    logic          expand_tabs_reg;
    logic [1:0]    action_reg;
    logic [7:0]    char_reg;
    logic [7:0]    color_reg;
    logic          in_range_reg;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          scroll_reg;
    logic          scroll_next;
    logic [AW-1:0] ptr_reg;
    logic          out_valid_reg;

    logic          is_nl;
    logic          is_tab;
    logic [CW:0]   col_adv;
    logic          row_adv;
    logic          in_range;
    logic [AW-1:0] rd_addr_in;
    logic [AW-1:0] cur_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // cursor advance for the latched character
    always_comb
    begin
        is_nl   = (char_reg == CH_NL) || (char_reg == CH_CR);
        is_tab  = (char_reg == CH_TAB) && expand_tabs_reg;
        col_adv = is_tab ? (({1'b0, col_reg} & TAB_MASK) + (CW + 1)'(TAB_STOP))
                         : ({1'b0, col_reg} + (CW + 1)'(1));
        row_adv = is_nl || (col_adv >= (CW + 1)'(COLUMNS));
    end

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        scroll_next = scroll_reg;
        if (cmd.req_load)
        begin
            scroll_next = 1'b0;
        end
        if (cmd.cur_home)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (cmd.cur_step)
        begin
            if (row_adv)
            begin
                col_next = '0;
                if (row_reg == RW'(ROWS - 1))
                begin
                    scroll_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_adv[CW-1:0];
            end
        end
    end

    always_comb
    begin
        in_range   = (32'(cell_row) < 32'(ROWS)) && (32'(cell_col) < 32'(COLUMNS));
        rd_addr_in = in_range ? (AW'(cell_row) * AW'(COLUMNS) + AW'(cell_col)) : '0;
        cur_addr   = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_in;
        case (cmd.mem_op)
            MEM_RD_REQ:
            begin
                ram_re = 1'b1;
            end
            MEM_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {color_reg, char_reg};
            end
            MEM_SCR_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_reg + AW'(COLUMNS);
            end
            MEM_SCR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            MEM_BLANK:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expand_tabs_reg <= 1'b0;
            row_reg         <= '0;
            col_reg         <= '0;
            scroll_reg      <= 1'b0;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expand_tabs_reg <= cfg_data;
            end
            row_reg    <= row_next;
            col_reg    <= col_next;
            scroll_reg <= scroll_next;
            if (cmd.ptr_clear)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            action_reg   <= action;
            char_reg     <= char_code;
            color_reg    <= color;
            in_range_reg <= in_range;
        end
        if (cmd.out_load)
        begin
            cursor_row <= 5'(row_next);
            cursor_col <= 7'(col_next);
            scrolled   <= scroll_next;
            read_data  <= ((action_reg == ACT_READ) && in_range_reg) ? ram_rdata : 16'h0000;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.action       = action_reg;
        status.is_glyph     = !is_nl && !is_tab;
        status.needs_scroll = row_adv && (row_reg == RW'(ROWS - 1));
        status.copy_end     = (ptr_reg == COPY_LAST);
        status.fill_end     = (ptr_reg == FILL_LAST);
        status.out_free     = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/core/text_console_writer_top.sv
// character-cell text console: a ROWS x COLUMNS screen of 16-bit cells (attribute byte high,
// character byte low) with a cursor. a put request writes the glyph at the cursor and advances,
// newline and carriage return go to column 0 of the next row, tab jumps to the next multiple of
// 4 when expand_tabs is set, and running off the last row scrolls the screen up one row with a
// blank bottom row (0x0120). clear blanks all cells and homes the cursor, read returns one cell
// (0 when the address is off screen). one request is in flight at a time; put, read and
// the unused code are accepted, then an execute state loads the result register if free,
// else a done state waits for it (a put that scrolls loads it after the scroll). the screen sits
// in a single-port-write ram, so a scroll reads then writes each moved cell, then fills the
// bottom row, and a clear blanks every cell. after reset in_ready stays low while the ram is
// blanked; write expand_tabs only with no request in flight. a finished result waits in the
// output register and does not block acceptance of the next request, only its completion.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [7:0]  color,
    input  logic [4:0]  cell_row,
    input  logic [6:0]  cell_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled,
    output logic [15:0] read_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer: decode, scroll copy, clear and result hand-off
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // cursor, screen ram, config register and result register
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .action     (action),
        .char_code  (char_code),
        .color      (color),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .read_data  (read_data)
    );

    // one request at a time: an accepted request closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a request is in flight");

    // a result is only loaded when the output register has room
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");

    // memory sweeps never overlap an open input side
    a_sweep_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ptr_inc |-> !in_ready)
        else $error("input open during a ram sweep");

    // a scroll always leaves the cursor at column 0
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_col == 7'd0)
        else $error("scroll result with nonzero column");

endmodule

// File: sim/text_console_writer_top_test.sv
module text_console_writer_top_test;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // screen geometry, matched to the instance below
    localparam int COLS = 80;
    localparam int ROWS = 25;

    // the action code the block leaves unused
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // run guard: sized so that even every request scrolling fits well inside
    localparam int CYCLE_LIMIT = 10_000_000;

    // one result as the block reports it
    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic        scrolled;
        logic [15:0] data;
    } console_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic        cfg_data   = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  action     = ACT_PUT;
    logic [7:0]  char_code  = 8'h00;
    logic [7:0]  color      = 8'h00;
    logic [4:0]  cell_row   = 5'd0;
    logic [6:0]  cell_col   = 7'd0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic [15:0] read_data;

    // shadow of the console: screen, cursor and tab mode
    logic [15:0] screen_model [0:ROWS*COLS-1];
    int          cur_row;
    int          cur_col;
    bit          tabs_on;

    // results still owed by the block, oldest first
    console_result_t expected_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // when set, neither side idles
    bit no_stalls = 1'b0;

    text_console_writer_top #(
        .COLUMNS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .char_code(char_code),
        .color(color),
        .cell_row(cell_row),
        .cell_col(cell_col),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cursor_row(cursor_row),
        .cursor_col(cursor_col),
        .scrolled(scrolled),
        .read_data(read_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------------------------------
    // console shadow
    // ---------------------------------------------------------------------------------------------

    task automatic blank_screen();
        for (int i = 0; i < ROWS * COLS; i++)
            screen_model[i] = BLANK_CELL;
    endtask

    // move to column 0 of the next row, scrolling when we run off the bottom
    task automatic advance_row(output bit rolled);
        cur_col = 0;
        cur_row++;
        rolled = 1'b0;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_model[i] = screen_model[i + COLS];
            for (int i = 0; i < COLS; i++)
                screen_model[(ROWS - 1) * COLS + i] = BLANK_CELL;
            cur_row = ROWS - 1;
            rolled = 1'b1;
        end
    endtask

    // apply one request to the shadow and work out what the block should report
    task automatic predict_console(input logic [1:0] act, input logic [7:0] ch,
                                   input logic [7:0] attr, input logic [4:0] rr,
                                   input logic [6:0] rc, output console_result_t res);
        bit          rolled;
        logic [15:0] cell_word;
        rolled = 1'b0;
        cell_word = '0;
        case (act)
            ACT_PUT:
            begin
                if (ch == CH_NL || ch == CH_CR)
                    advance_row(rolled);
                else if (ch == CH_TAB && tabs_on)
                begin
                    cur_col += TAB_STOP - (cur_col % TAB_STOP);
                    if (cur_col >= COLS)
                        advance_row(rolled);
                end
                else
                begin
                    screen_model[cur_row * COLS + cur_col] = {attr, ch};
                    cur_col++;
                    if (cur_col >= COLS)
                        advance_row(rolled);
                end
            end
            ACT_CLEAR:
            begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ:
            begin
                // off-screen addresses read back as zero
                if (rr < ROWS && rc < COLS)
                    cell_word = screen_model[rr * COLS + rc];
            end
            default: ;
        endcase
        res.row      = cur_row[4:0];
        res.col      = cur_col[6:0];
        res.scrolled = rolled;
        res.data     = cell_word;
    endtask

    // ---------------------------------------------------------------------------------------------
    // idle lengths: mostly none or short, now and then long
    // ---------------------------------------------------------------------------------------------

    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_stalls || pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------------------------------

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic [1:0] act, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [4:0] rr,
                                input logic [6:0] rc);
        int              gap;
        console_result_t res;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        char_code <= ch;
        color     <= attr;
        cell_row  <= rr;
        cell_col  <= rc;
        do
            @(posedge clk);
        while (!in_ready);
        // taken at this edge: the shadow moves in acceptance order
        predict_console(act, ch, attr, rr, rc, res);
        expected_results.push_back(res);
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // tab mode only changes with the block idle
    task automatic write_tab_mode(input bit mode);
        wait_for_results();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tabs_on = mode;
    endtask

    // one random request; rates are per thousand
    task automatic send_random_request(input int nl_pm, input int tab_pm, input int odd_pm);
        int          pick;
        logic [7:0]  attr;
        logic [4:0]  rr;
        logic [6:0]  rc;
        pick = $urandom_range(0, 999);
        attr = 8'($urandom);
        rr   = 5'($urandom);
        rc   = 7'($urandom);
        if (pick < nl_pm)
            send_request(ACT_PUT, $urandom_range(0, 1) ? CH_NL : CH_CR, attr, rr, rc);
        else if (pick < nl_pm + tab_pm)
            send_request(ACT_PUT, CH_TAB, attr, rr, rc);
        else if (pick < nl_pm + tab_pm + 70)
            // on-screen read, biased toward the cursor row where text just went
            send_request(ACT_READ, 8'($urandom), attr,
                         $urandom_range(0, 1) ? cur_row[4:0] : 5'($urandom_range(0, ROWS - 1)),
                         7'($urandom_range(0, COLS - 1)));
        else if (pick < nl_pm + tab_pm + 74)
            send_request(ACT_CLEAR, 8'($urandom), attr, rr, rc);
        else if (pick < nl_pm + tab_pm + 74 + odd_pm)
        begin
            // noise: the spare code, or a read at any address the fields allow
            if ($urandom_range(0, 1))
                send_request(ACT_SPARE, 8'($urandom), attr, rr, rc);
            else
                send_request(ACT_READ, 8'($urandom), attr, rr, rc);
        end
        else
            send_request(ACT_PUT, 8'($urandom), attr, rr, rc);
    endtask

    // ---------------------------------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------------------------------

    // out_ready toggles between random stalls and short ready bursts
    initial
    begin : result_stalls
        int gap;
        forever
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        console_result_t got;
        console_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {cursor_row, cursor_col, scrolled, read_data};
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: row %0d col %0d scrolled %0d data %04h",
                             got.row, got.col, got.scrolled, got.data);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.scrolled !== want.scrolled || got.data !== want.data)
                begin
                    if (mismatch_count < 10)
                        $display({"mismatch: expected row %0d col %0d scrolled %0d data %04h,",
                                  " got row %0d col %0d scrolled %0d data %04h"},
                                 want.row, want.col, want.scrolled, want.data,
                                 got.row, got.col, got.scrolled, got.data);
                    mismatch_count++;
                end
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_console_writer_top_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------------------

    // glyph and color extremes, reads at the screen corners and just off it, the spare code
    task automatic test_cell_extremes();
        send_request(ACT_PUT, 8'h00, 8'h00, 5'd0, 7'd0);
        send_request(ACT_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127);
        send_request(ACT_PUT, 8'hA5, 8'h5A, 5'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0);
        send_request(ACT_READ, 8'hFF, 8'hFF, 5'd0, 7'd1);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd2);
        send_request(ACT_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
        send_request(ACT_READ, 8'h00, 8'h00, 5'(ROWS), 7'd0);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd0, 7'(COLS));
        send_request(ACT_READ, 8'h00, 8'h00, 5'd31, 7'd127);
        send_request(ACT_SPARE, 8'hFF, 8'hFF, 5'd31, 7'd127);
    endtask

    // newline, carriage return, tab as a glyph and tab as a column jump
    task automatic test_control_chars();
        send_request(ACT_PUT, CH_NL, 8'h07, 5'd0, 7'd0);
        send_request(ACT_PUT, CH_CR, 8'h07, 5'd0, 7'd0);
        send_request(ACT_PUT, CH_TAB, 8'h1E, 5'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd2, 7'd0);
        write_tab_mode(1'b1);
        send_request(ACT_PUT, 8'h61, 8'h0F, 5'd0, 7'd0);
        send_request(ACT_PUT, CH_TAB, 8'h0F, 5'd0, 7'd0);
        send_request(ACT_PUT, CH_TAB, 8'h0F, 5'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd2, 7'd2);
        write_tab_mode(1'b0);
    endtask

    // clear blanks the screen and homes the cursor
    task automatic test_clear_home();
        send_request(ACT_PUT, 8'h78, 8'h4E, 5'd0, 7'd0);
        send_request(ACT_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 8'h00, 5'd2, 7'd1);
    endtask

    // running text with tabs stored as glyphs: long lines wrap
    task automatic test_plain_text();
        write_tab_mode(1'b0);
        for (int i = 0; i < 160; i++)
        begin
            no_stalls = (i >= 40 && i < 80);
            send_random_request(60, 20, 10);
        end
        no_stalls = 1'b0;
    endtask

    // tab-heavy text with expansion on, so tabs land near and past the row end
    task automatic test_expanded_tabs();
        write_tab_mode(1'b1);
        for (int i = 0; i < 160; i++)
        begin
            no_stalls = (i >= 100 && i < 130);
            send_random_request(25, 200, 10);
        end
        no_stalls = 1'b0;
    endtask

    // more noise, with the tab mode flipped half way
    task automatic test_mixed_noise();
        write_tab_mode(1'b0);
        for (int i = 0; i < 40; i++)
            send_random_request(50, 100, 120);
        write_tab_mode(1'b1);
        for (int i = 0; i < 40; i++)
            send_random_request(50, 100, 120);
    endtask

    initial
    begin
        tabs_on = 1'b0;
        cur_row = 0;
        cur_col = 0;
        blank_screen();

        // reset once, held low and then released
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_tab_mode(1'b0);
        test_cell_extremes();
        test_control_chars();
        test_clear_home();
        test_plain_text();
        test_expanded_tabs();
        test_mixed_noise();

        // all requests in; collect the tail and watch for strays
        wait_for_results();
        repeat (16) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("text_console_writer_top_test: done, clean");
        else
            $display("text_console_writer_top_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer_top.sv
sim/text_console_writer_top_test.sv
